>>> design/vlsas_pkg.sv
`default_nettype none

package vlsas_pkg;

	localparam int unsigned MAX_ELEMENTS = 64;
	localparam int unsigned IDX_W        = $clog2(MAX_ELEMENTS);
	localparam int unsigned VL_W         = IDX_W + 1;
	localparam int unsigned QUEUE_DEPTH  = 2;
	localparam int unsigned QPTR_W       = $clog2(QUEUE_DEPTH);
	localparam int unsigned QCNT_W       = $clog2(QUEUE_DEPTH + 1);

	// element width codes, instruction bits 14:12
	localparam logic [2:0] EEW_8  = 3'd0;
	localparam logic [2:0] EEW_16 = 3'd5;
	localparam logic [2:0] EEW_32 = 3'd6;
	localparam logic [2:0] EEW_64 = 3'd7;

	// addressing mode codes, instruction bits 27:26
	localparam logic [1:0] MOP_UNIT    = 2'd0;
	localparam logic [1:0] MOP_INDEXED = 2'd1;
	localparam logic [1:0] MOP_STRIDED = 2'd2;

	// config register indexes (paddr[4:3])
	localparam logic [1:0] REG_VECTOR_LENGTH = 2'd0;
	localparam logic [1:0] REG_START_INDEX   = 2'd1;
	localparam logic [1:0] REG_ELEMENT_MASK  = 2'd2;

	typedef enum logic [1:0] {
		ST_ACCESS  = 2'd0,
		ST_EMPTY   = 2'd1,
		ST_ILLEGAL = 2'd2
	} status_t;

	typedef struct packed {
		logic [VL_W-1:0]         vl;
		logic [IDX_W-1:0]        start;
		logic [MAX_ELEMENTS-1:0] mask;
	} cfg_t;

	// decoded instruction handed from front to back
	typedef struct packed {
		status_t                 kind;
		logic [63:0]             base;
		logic [31:0]             step;
		logic [3:0]              bytes;
		logic                    wr;
		logic [4:0]              vreg;
		logic [IDX_W-1:0]        start;
		logic [MAX_ELEMENTS-1:0] active;
	} desc_t;

	typedef struct packed {
		status_t          status;
		logic [63:0]      addr;
		logic [3:0]       bytes;
		logic             wr;
		logic [4:0]       vreg;
		logic [IDX_W-1:0] idx;
		logic             last;
	} result_t;

	typedef struct packed {
		logic full;
		logic valid;
	} qstat_t;

endpackage

`default_nettype wire

>>> design/vector_load_store_address_sequencer_unit.sv
// An accepted item goes into the queue, then the walker's working registers, and its first
//   result is registered. The single back-end walker visits one element slot per cycle,
//   unless the result is stalled, from start_index to the last active element (masked slots
//   too), after a load step per item; empty and illegal items give a load step and one result.
// A two-entry queue lets the next item be accepted while the back end works.
// Reset (arst_n low, asynchronous): queue empty, walker idle, no result, config 0.
`default_nettype none

module vector_load_store_address_sequencer_unit import vlsas_pkg::*; (
	input  wire logic         clk,
	input  wire logic         arst_n,
	// input item stream
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [127:0] s_tdata,  // instruction_word, base_address, stride_value
	input  wire logic [0:0]   s_tuser,  // operation
	// result stream
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic [79:0]       m_tdata,  // access_address, access_bytes, vector_register,
	                                    // element_index, zero pad
	output logic [2:0]        m_tuser,  // status, is_write
	output logic              m_tlast,
	// config port
	input  wire logic         psel,
	input  wire logic         penable,
	input  wire logic         pwrite,
	input  wire logic [4:0]   paddr,
	input  wire logic [63:0]  pwdata,
	output logic [63:0]       prdata,
	output logic              pready
);

	cfg_t    cfg_q;
	logic    cfg_wr;
	desc_t   front_desc;
	desc_t   q_head;
	qstat_t  q_stat;
	logic    q_pop;
	logic    out_valid;
	result_t out;

	// ---------------- config registers (64-bit slots, 8-byte stride) ----------------
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_wr) begin
			case (paddr[4:3])
				REG_VECTOR_LENGTH: cfg_q.vl    <= pwdata[VL_W-1:0];
				REG_START_INDEX:   cfg_q.start <= pwdata[IDX_W-1:0];
				REG_ELEMENT_MASK:  cfg_q.mask  <= pwdata[MAX_ELEMENTS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (paddr[4:3])
			REG_VECTOR_LENGTH: prdata[VL_W-1:0]         = cfg_q.vl;
			REG_START_INDEX:   prdata[IDX_W-1:0]        = cfg_q.start;
			REG_ELEMENT_MASK:  prdata[MAX_ELEMENTS-1:0] = cfg_q.mask;
			default:           prdata = '0;
		endcase
	end

	// ---------------- front: decode and legality, combinational into queue ----------------
	vlsas_front u_front (
		.operation        (s_tuser[0]),
		.instruction_word (s_tdata[31:0]),
		.base_address     (s_tdata[95:32]),
		.stride_value     (s_tdata[127:96]),
		.cfg              (cfg_q),
		.desc             (front_desc)
	);

	assign s_tready = !q_stat.full;

	vlsas_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (s_tvalid),
		.push_desc (front_desc),
		.pop       (q_pop),
		.head      (q_head),
		.stat      (q_stat)
	);

	// ---------------- back: element walker with registered result ----------------
	vlsas_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_stat.valid),
		.q_head    (q_head),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_ready (m_tready),
		.out       (out)
	);

	assign m_tvalid = out_valid;
	assign m_tlast  = out.last;
	assign m_tuser  = {out.wr, out.status};
	assign m_tdata  = {1'b0, out.idx, out.vreg, out.bytes, out.addr};

	// ---------------- checks ----------------
	// empty and illegal results always close their instruction
	a_nonaccess_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1:0] != ST_ACCESS |-> m_tlast)
		else $error("non-access result without last");

	// empty and illegal results carry zero payload
	a_nonaccess_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1:0] != ST_ACCESS |-> m_tdata == '0 && !m_tuser[2])
		else $error("non-access result with nonzero payload");

	// element accesses carry a power-of-two size
	a_access_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1:0] == ST_ACCESS |-> $onehot(m_tdata[67:64]))
		else $error("access with bad element size");

endmodule

`default_nettype wire

>>> design/vlsas_front.sv
`default_nettype none

module vlsas_front import vlsas_pkg::*; (
	input  wire logic        operation,
	input  wire logic [31:0] instruction_word,
	input  wire logic [63:0] base_address,
	input  wire logic [31:0] stride_value,
	input  wire cfg_t        cfg,
	output desc_t            desc
);

	logic [1:0]              mop;
	logic                    mew;
	logic                    vm;
	logic [2:0]              wcode;
	logic                    width_ok;
	logic                    mode_ok;
	logic                    len_ok;
	logic [1:0]              bytes_log2;
	logic [31:0]             stride;
	logic [VL_W:0]           len_sum;
	logic [MAX_ELEMENTS-1:0] lo_mask;
	logic [MAX_ELEMENTS-1:0] hi_mask;
	logic [MAX_ELEMENTS-1:0] active;

	assign mop   = instruction_word[27:26];
	assign mew   = instruction_word[28];
	assign vm    = instruction_word[25];
	assign wcode = instruction_word[14:12];

	always_comb begin
		width_ok   = 1'b1;
		bytes_log2 = 2'd0;
		case (wcode)
			EEW_8:   bytes_log2 = 2'd0;
			EEW_16:  bytes_log2 = 2'd1;
			EEW_32:  bytes_log2 = 2'd2;
			EEW_64:  bytes_log2 = 2'd3;
			default: width_ok   = 1'b0;
		endcase
	end

	always_comb begin
		mode_ok = 1'b1;
		stride  = 32'd1;
		case (mop)
			MOP_UNIT:    stride = 32'd1;
			MOP_STRIDED: stride = stride_value;
			default:     mode_ok = 1'b0;
		endcase
	end

	assign len_sum = {2'b00, cfg.start} + {1'b0, cfg.vl};
	assign len_ok  = len_sum <= (VL_W+1)'(MAX_ELEMENTS);

	// elements in [start, vl); vl above the slot count is already illegal
	assign lo_mask = {MAX_ELEMENTS{1'b1}} << cfg.start;
	assign hi_mask = cfg.vl[VL_W-1] ? {MAX_ELEMENTS{1'b1}}
	               : ({{(MAX_ELEMENTS-1){1'b0}}, 1'b1} << cfg.vl[IDX_W-1:0])
	                 - {{(MAX_ELEMENTS-1){1'b0}}, 1'b1};
	assign active  = lo_mask & hi_mask & (vm ? cfg.mask : {MAX_ELEMENTS{1'b1}});

	always_comb begin
		desc.base   = base_address;
		desc.step   = stride << bytes_log2;
		desc.bytes  = 4'd1 << bytes_log2;
		desc.wr     = operation;
		desc.vreg   = instruction_word[11:7];
		desc.start  = cfg.start;
		desc.active = active;
		if (!(width_ok && mode_ok && !mew && len_ok))
			desc.kind = ST_ILLEGAL;
		else if (active == '0)
			desc.kind = ST_EMPTY;
		else
			desc.kind = ST_ACCESS;
	end

endmodule

`default_nettype wire

>>> design/vlsas_queue.sv
`default_nettype none

module vlsas_queue import vlsas_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	input  wire desc_t push_desc,
	input  wire logic  pop,
	output desc_t      head,
	output qstat_t     stat
);

	desc_t             mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_push;
	logic              do_pop;

	assign stat.full  = count_q == QCNT_W'(QUEUE_DEPTH);
	assign stat.valid = count_q != '0;
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && stat.valid;
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= push_desc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (do_pop && !do_push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

`default_nettype wire

>>> design/vlsas_back.sv
`default_nettype none

module vlsas_back import vlsas_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  q_valid,
	input  wire desc_t q_head,
	output logic       q_pop,
	output logic       out_valid,
	input  wire logic  out_ready,
	output result_t    out
);

	logic                    busy_q;
	logic                    out_valid_q;
	result_t                 out_q;
	status_t                 kind_q;
	logic [63:0]             base_q;
	logic [31:0]             step_q;
	logic [31:0]             offset_q;
	logic [3:0]              bytes_q;
	logic                    wr_q;
	logic [4:0]              vreg_q;
	logic [IDX_W-1:0]        idx_q;
	logic [MAX_ELEMENTS-1:0] mask_q;
	logic [MAX_ELEMENTS-1:0] mask_nxt;
	logic                    adv;
	logic                    hit;

	assign q_pop     = !busy_q && q_valid;
	assign adv       = busy_q && (!out_valid_q || out_ready);
	assign hit       = mask_q[idx_q];
	assign out_valid = out_valid_q;
	assign out       = out_q;

	always_comb begin
		mask_nxt        = mask_q;
		mask_nxt[idx_q] = 1'b0;
	end

	// working registers and result payload
	always_ff @(posedge clk) begin
		if (q_pop) begin
			kind_q   <= q_head.kind;
			base_q   <= q_head.base;
			step_q   <= q_head.step;
			offset_q <= '0;
			bytes_q  <= q_head.bytes;
			wr_q     <= q_head.wr;
			vreg_q   <= q_head.vreg;
			idx_q    <= q_head.start;
			mask_q   <= q_head.active;
		end else if (adv) begin
			mask_q   <= mask_nxt;
			idx_q    <= idx_q + 1'b1;
			offset_q <= offset_q + step_q;
		end
		if (adv) begin
			if (kind_q == ST_ACCESS) begin
				out_q.status <= ST_ACCESS;
				out_q.addr   <= base_q + {{32{offset_q[31]}}, offset_q};
				out_q.bytes  <= bytes_q;
				out_q.wr     <= wr_q;
				out_q.vreg   <= vreg_q;
				out_q.idx    <= idx_q;
				out_q.last   <= mask_nxt == '0;
			end else begin
				out_q.status <= kind_q;
				out_q.addr   <= '0;
				out_q.bytes  <= '0;
				out_q.wr     <= 1'b0;
				out_q.vreg   <= '0;
				out_q.idx    <= '0;
				out_q.last   <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop)
				busy_q <= 1'b1;
			else if (adv && (kind_q != ST_ACCESS || mask_nxt == '0))
				busy_q <= 1'b0;
			if (adv && (kind_q != ST_ACCESS || hit))
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

endmodule

`default_nettype wire
